>>> rtl/core/cpp_pkg.sv
// ----------------------------------------------------------------------------
// cpp_pkg: shared types and constants for the closest point block
// Coordinate widths, derived arithmetic widths and the control structs that
// run between the top level, the segment sequencer and the serial divider.
// ----------------------------------------------------------------------------
package cpp_pkg;

   localparam int COORD_W    = 16;
   localparam int DIFF_W     = COORD_W + 1;       // edge vector, point offset
   localparam int PROD_W     = 2 * DIFF_W;        // one signed product
   localparam int LEN2_W     = PROD_W;            // squared edge length
   localparam int DOT_W      = PROD_W + 1;        // signed dot product
   localparam int DIST_W     = 2 * COORD_W + 4;   // squared distance
   localparam int DIV_CNT_W  = $clog2(DIFF_W);
   localparam int REQ_DATA_W = 4 * COORD_W;
   localparam int RSP_DATA_W = 2 * COORD_W;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;

   typedef struct packed {
      logic      start;
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by;
      coord_type px;
      coord_type py;
   } seg_req_type;

   typedef struct packed {
      logic              done;
      coord_type         qx;
      coord_type         qy;
      logic [DIST_W-1:0] d2;
   } seg_rsp_type;

   typedef struct packed {
      logic              start;
      logic [LEN2_W-1:0] num;
      logic [LEN2_W-1:0] den;
      logic [DIFF_W-1:0] mag;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIFF_W-1:0] quo;
   } div_rsp_type;

endpackage

>>> rtl/core/cpp_serdiv.sv
// ----------------------------------------------------------------------------
// cpp_serdiv: bit-serial scaled divider
// Computes round(num * mag / den), ties away from zero, for num < den. The
// multiplier bits of mag are shifted in MSB first, each as a shift step then an add step.
// ----------------------------------------------------------------------------
module cpp_serdiv
   import cpp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   typedef enum logic [1:0] {D_IDLE, D_SHIFT, D_ADD, D_ROUND} dstate_type;

   dstate_type           state_ff, state_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [LEN2_W-1:0]    rem_ff, rem_in;
   logic [LEN2_W-1:0]    num_ff, den_ff;
   logic [DIFF_W-1:0]    mag_ff, mag_in;
   logic [DIFF_W-1:0]    quo_ff, quo_in;
   logic [LEN2_W:0]      trial;
   logic [LEN2_W:0]      trial_sub;
   logic                 fits;
   logic                 load;

   // shift phase doubles the remainder, add phase folds in num on a set bit
   always_comb begin
      if (state_ff == D_ADD) begin
         trial = {1'b0, rem_ff} + (mag_ff[DIFF_W-1] ? {1'b0, num_ff} : '0);
      end else begin
         trial = {rem_ff, 1'b0};
      end
      trial_sub = trial - {1'b0, den_ff};
      fits      = trial >= {1'b0, den_ff};
   end

   assign load = (state_ff == D_IDLE) && div_req.start;

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      mag_in   = mag_ff;
      quo_in   = quo_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (div_req.start) begin
               rem_in   = '0;
               quo_in   = '0;
               mag_in   = div_req.mag;
               cnt_in   = DIV_CNT_W'(DIFF_W - 1);
               state_in = D_SHIFT;
            end
         end
         D_SHIFT: begin
            rem_in   = fits ? trial_sub[LEN2_W-1:0] : trial[LEN2_W-1:0];
            quo_in   = {quo_ff[DIFF_W-2:0], fits};
            state_in = D_ADD;
         end
         D_ADD: begin
            rem_in = fits ? trial_sub[LEN2_W-1:0] : trial[LEN2_W-1:0];
            quo_in = quo_ff + {{(DIFF_W-1){1'b0}}, fits};
            mag_in = {mag_ff[DIFF_W-2:0], 1'b0};
            if (cnt_ff == '0) begin
               state_in = D_ROUND;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = D_SHIFT;
            end
         end
         D_ROUND: begin
            // twice the remainder against den decides the rounding step
            quo_in   = quo_ff + {{(DIFF_W-1){1'b0}}, fits};
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      mag_ff <= mag_in;
      quo_ff <= quo_in;
      if (load) begin
         num_ff <= div_req.num;
         den_ff <= div_req.den;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

>>> rtl/core/cpp_segment.sv
// ----------------------------------------------------------------------------
// cpp_segment: projection of the test point onto one segment
// Sequences a shared registered multiplier for len2, dot and the squared
// distance, and the serial divider for the two projection offsets.
// ----------------------------------------------------------------------------
module cpp_segment
   import cpp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  seg_req_type seg_req,
   output seg_rsp_type seg_rsp
);

   typedef enum logic [3:0] {
      E_IDLE, E_LL0, E_LL1, E_DT0, E_DT1, E_DT2, E_DEC,
      E_DVX, E_WTX, E_DVY, E_WTY, E_DS0, E_DS1, E_DS2
   } estate_type;

   estate_type               state_ff, state_in;
   logic                     done_ff, done_in;
   coord_type                ax_ff, ay_ff, bx_ff, by_ff, px_ff, py_ff;
   coord_type                qx_ff, qx_in, qy_ff, qy_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic [LEN2_W-1:0]        len2_ff, len2_in;
   logic [DOT_W-1:0]         dot_ff, dot_in;
   logic [DIST_W-1:0]        d2_ff, d2_in;
   diff_type                 ex, ey, wx, wy, dx, dy;
   diff_type                 mul_a, mul_b;
   diff_type                 sel_e;
   logic [DIFF_W-1:0]        sel_mag;
   logic [DIFF_W-1:0]        offset;
   logic [DOT_W-1:0]         sum;
   logic                     dot_pos;
   logic                     past_end;
   logic                     load;
   div_req_type              div_req;
   div_rsp_type              div_rsp;

   cpp_serdiv u_serdiv (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign ex = {bx_ff[COORD_W-1], bx_ff} - {ax_ff[COORD_W-1], ax_ff};
   assign ey = {by_ff[COORD_W-1], by_ff} - {ay_ff[COORD_W-1], ay_ff};
   assign wx = {px_ff[COORD_W-1], px_ff} - {ax_ff[COORD_W-1], ax_ff};
   assign wy = {py_ff[COORD_W-1], py_ff} - {ay_ff[COORD_W-1], ay_ff};
   assign dx = {px_ff[COORD_W-1], px_ff} - {qx_ff[COORD_W-1], qx_ff};
   assign dy = {py_ff[COORD_W-1], py_ff} - {qy_ff[COORD_W-1], qy_ff};

   assign sum = {prod_ff[PROD_W-1], prod_ff} + {acc_ff[PROD_W-1], acc_ff};

   // y axis shares the divider after x
   assign sel_e   = (state_ff == E_DVY || state_ff == E_WTY) ? ey : ex;
   assign sel_mag = sel_e[DIFF_W-1] ? (~sel_e + 1'b1) : sel_e;
   assign offset  = sel_e[DIFF_W-1] ? (~div_rsp.quo + 1'b1) : div_rsp.quo;

   assign dot_pos  = !dot_ff[DOT_W-1] && (dot_ff != '0);
   assign past_end = dot_ff[LEN2_W-1:0] >= len2_ff;

   assign div_req.start = (state_ff == E_DVX) || (state_ff == E_DVY);
   assign div_req.num   = dot_ff[LEN2_W-1:0];
   assign div_req.den   = len2_ff;
   assign div_req.mag   = sel_mag;

   assign load = (state_ff == E_IDLE) && seg_req.start;

   always_comb begin
      unique case (state_ff)
         E_LL1: begin
            mul_a = ey;
            mul_b = ey;
         end
         E_DT0: begin
            mul_a = wx;
            mul_b = ex;
         end
         E_DT1: begin
            mul_a = wy;
            mul_b = ey;
         end
         E_DS0: begin
            mul_a = dx;
            mul_b = dx;
         end
         E_DS1: begin
            mul_a = dy;
            mul_b = dy;
         end
         default: begin
            mul_a = ex;
            mul_b = ex;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      acc_in   = acc_ff;
      len2_in  = len2_ff;
      dot_in   = dot_ff;
      qx_in    = qx_ff;
      qy_in    = qy_ff;
      d2_in    = d2_ff;
      unique case (state_ff)
         E_IDLE: begin
            if (seg_req.start) begin
               state_in = E_LL0;
            end
         end
         E_LL0: begin
            state_in = E_LL1;
         end
         E_LL1: begin
            acc_in   = prod_ff;
            state_in = E_DT0;
         end
         E_DT0: begin
            len2_in  = sum[LEN2_W-1:0];
            state_in = E_DT1;
         end
         E_DT1: begin
            acc_in   = prod_ff;
            state_in = E_DT2;
         end
         E_DT2: begin
            dot_in   = sum;
            state_in = E_DEC;
         end
         E_DEC: begin
            // degenerate edge or point behind the start clamps to a, past the end to b
            priority if (len2_ff == '0 || !dot_pos) begin
               qx_in    = ax_ff;
               qy_in    = ay_ff;
               state_in = E_DS0;
            end else if (past_end) begin
               qx_in    = bx_ff;
               qy_in    = by_ff;
               state_in = E_DS0;
            end else begin
               state_in = E_DVX;
            end
         end
         E_DVX: begin
            state_in = E_WTX;
         end
         E_WTX: begin
            if (div_rsp.done) begin
               qx_in    = ax_ff + offset[COORD_W-1:0];
               state_in = E_DVY;
            end
         end
         E_DVY: begin
            state_in = E_WTY;
         end
         E_WTY: begin
            if (div_rsp.done) begin
               qy_in    = ay_ff + offset[COORD_W-1:0];
               state_in = E_DS0;
            end
         end
         E_DS0: begin
            state_in = E_DS1;
         end
         E_DS1: begin
            acc_in   = prod_ff;
            state_in = E_DS2;
         end
         E_DS2: begin
            d2_in    = {{(DIST_W-DOT_W){1'b0}}, sum};
            done_in  = 1'b1;
            state_in = E_IDLE;
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      acc_ff  <= acc_in;
      len2_ff <= len2_in;
      dot_ff  <= dot_in;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      d2_ff   <= d2_in;
      if (load) begin
         ax_ff <= seg_req.ax;
         ay_ff <= seg_req.ay;
         bx_ff <= seg_req.bx;
         by_ff <= seg_req.by;
         px_ff <= seg_req.px;
         py_ff <= seg_req.py;
      end
   end

   assign seg_rsp.done = done_ff;
   assign seg_rsp.qx   = qx_ff;
   assign seg_rsp.qy   = qy_ff;
   assign seg_rsp.d2   = d2_ff;

endmodule

>>> rtl/core/closest_point_on_polygon.sv
// ----------------------------------------------------------------------------
// closest_point_on_polygon: nearest point on a polygon boundary
// Streams polygon vertices in, returns the boundary point nearest the test
// point carried with the polygon's first vertex.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  one vertex item per handshake; req_tlast marks the final vertex.
//          The test point is taken from the first vertex item of a polygon.
//   rsp_*  one result item per polygon, sent after the closing edge.
// Sequencing, set by the segment sequencer and its shared bit-serial divider:
//   first vertex of a polygon: accepted back to back, no edge work
//   each later vertex: one edge; both offsets are divided unless the
//     projection clamps to an end point or the edge has zero length
//   last vertex: that edge plus the closing edge, then the result register
//     is loaded once it is free; a single vertex polygon is one closing edge.
// Reset: synchronous; clears the sequencers, drops rsp_tvalid and arms the
//   block to start a new polygon with the next item.
// Stall: the result sits in an output register; the next polygon is taken
//   while it waits, and only its own result waits for that register.
// ----------------------------------------------------------------------------
module closest_point_on_polygon
   import cpp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // req_tdata fields, from bit 0: vertex_x, vertex_y, point_x, point_y
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata fields, from bit 0: closest_x, closest_y
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   typedef enum logic [1:0] {T_IDLE, T_EDGE, T_CLOSE, T_EMIT} tstate_type;

   tstate_type            state_ff, state_in;
   logic                  poly_start_ff, poly_start_in;
   logic                  best_valid_ff, best_valid_in;
   logic                  last_ff, last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   coord_type             first_x_ff, first_y_ff;
   coord_type             prev_x_ff, prev_y_ff;
   coord_type             point_x_ff, point_y_ff;
   coord_type             best_x_ff, best_y_ff;
   logic [DIST_W-1:0]     best_d2_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   coord_type             vertex_x, vertex_y, point_x, point_y;
   logic                  accept;
   logic                  take;
   logic                  emit;
   seg_req_type           seg_req;
   seg_rsp_type           seg_rsp;

   assign vertex_x = req_tdata[COORD_W-1:0];
   assign vertex_y = req_tdata[2*COORD_W-1:COORD_W];
   assign point_x  = req_tdata[3*COORD_W-1:2*COORD_W];
   assign point_y  = req_tdata[4*COORD_W-1:3*COORD_W];

   assign req_tready = (state_ff == T_IDLE);
   assign accept     = req_tvalid && req_tready;

   // strict less-than: the earliest edge keeps a tie
   assign take = seg_rsp.done && (!best_valid_ff || seg_rsp.d2 < best_d2_ff);
   assign emit = (state_ff == T_EMIT) && (!rsp_valid_ff || rsp_tready);

   cpp_segment u_segment (
      .clock   (clock),
      .reset   (reset),
      .seg_req (seg_req),
      .seg_rsp (seg_rsp)
   );

   // segment operands: the new edge from an incoming vertex, else the
   // closing edge from the last vertex back to the first
   always_comb begin
      seg_req.start = 1'b0;
      seg_req.ax    = prev_x_ff;
      seg_req.ay    = prev_y_ff;
      seg_req.bx    = first_x_ff;
      seg_req.by    = first_y_ff;
      seg_req.px    = point_x_ff;
      seg_req.py    = point_y_ff;
      if (state_ff == T_IDLE) begin
         seg_req.start = accept && (!poly_start_ff || req_tlast);
         seg_req.ax    = poly_start_ff ? vertex_x : prev_x_ff;
         seg_req.ay    = poly_start_ff ? vertex_y : prev_y_ff;
         seg_req.bx    = vertex_x;
         seg_req.by    = vertex_y;
         seg_req.px    = poly_start_ff ? point_x : point_x_ff;
         seg_req.py    = poly_start_ff ? point_y : point_y_ff;
      end else if (state_ff == T_EDGE) begin
         seg_req.start = seg_rsp.done && last_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      poly_start_in = poly_start_ff;
      best_valid_in = best_valid_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         best_valid_in = 1'b1;
      end
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               last_in = req_tlast;
               if (poly_start_ff) begin
                  poly_start_in = 1'b0;
                  best_valid_in = 1'b0;
                  if (req_tlast) begin
                     state_in = T_CLOSE;
                  end
               end else begin
                  state_in = T_EDGE;
               end
            end
         end
         T_EDGE: begin
            if (seg_rsp.done) begin
               state_in = last_ff ? T_CLOSE : T_IDLE;
            end
         end
         T_CLOSE: begin
            if (seg_rsp.done) begin
               state_in = T_EMIT;
            end
         end
         T_EMIT: begin
            if (emit) begin
               rsp_valid_in  = 1'b1;
               poly_start_in = 1'b1;
               best_valid_in = 1'b0;
               state_in      = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_IDLE;
         poly_start_ff <= 1'b1;
         best_valid_ff <= 1'b0;
         last_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         poly_start_ff <= poly_start_in;
         best_valid_ff <= best_valid_in;
         last_ff       <= last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prev_x_ff <= vertex_x;
         prev_y_ff <= vertex_y;
         if (poly_start_ff) begin
            first_x_ff <= vertex_x;
            first_y_ff <= vertex_y;
            point_x_ff <= point_x;
            point_y_ff <= point_y;
         end
      end
      if (take) begin
         best_x_ff  <= seg_rsp.qx;
         best_y_ff  <= seg_rsp.qy;
         best_d2_ff <= seg_rsp.d2;
      end
      if (emit) begin
         rsp_data_ff <= {best_y_ff, best_x_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/core/cpp_checker.sv
// ----------------------------------------------------------------------------
// cpp_checker: port-level checks for closest_point_on_polygon
// Watches the stream ports for result hold, reset behavior, the busy window
// that follows a last vertex item and no result item rising straight after an accepted item.
// ----------------------------------------------------------------------------
module cpp_checker
   import cpp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic req_accept;

   assign req_accept = req_tvalid && req_tready;

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("ports not idle after reset");

   // a last vertex always starts the closing edge
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> !req_tready)
      else $error("input ready right after a last vertex item");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !$rose(rsp_tvalid))
      else $error("result item appeared right after an accepted item");

endmodule

bind closest_point_on_polygon cpp_checker u_cpp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
